[hdl/grouped_variance_stddev_unit_assert.svh]
// Assertion macros shared by the grouped variance unit modules
`ifndef GROUPED_VARIANCE_STDDEV_UNIT_ASSERT_SVH
`define GROUPED_VARIANCE_STDDEV_UNIT_ASSERT_SVH

// Same-cycle implication, reset disables the check
`define GVS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset disables the check
`define GVS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/gvs_pkg.sv]
// Package: shared types, codes and constants of the grouped variance unit
`timescale 1ns / 1ps

package gvs_pkg;

    // Default sizing
    localparam int DEF_MAX_ITEMS  = 1024;
    localparam int DEF_MAX_GROUPS = 64;
    localparam int DEF_FRAC_BITS  = 16;

    // Fixed field widths
    localparam int SAMPLE_W = 32;
    localparam int KEY_W    = 32;
    localparam int IDX_IN_W = 10;
    localparam int RESULT_W = 32;
    localparam int DEV_W    = 64;
    localparam int ROOT_W   = 32;

    typedef logic [1:0] t_mode;
    typedef logic [1:0] t_status;
    typedef logic [1:0] t_res_sel;

    // Request modes
    localparam t_mode MODE_LOAD  = 2'd0;
    localparam t_mode MODE_QUERY = 2'd1;
    localparam t_mode MODE_CLEAR = 2'd2;
    localparam t_mode MODE_NONE  = 2'd3;

    // Response status codes
    localparam t_status ST_OK         = 2'd0;
    localparam t_status ST_BAD_INDEX  = 2'd1;
    localparam t_status ST_GROUP_FULL = 2'd2;
    localparam t_status ST_STORE_FULL = 2'd3;

    // Operation register values
    localparam logic OP_STDDEV   = 1'b0;
    localparam logic OP_VARIANCE = 1'b1;

    // Result source select
    localparam t_res_sel SEL_ZERO = 2'd0;
    localparam t_res_sel SEL_QUO  = 2'd1;
    localparam t_res_sel SEL_ROOT = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic     latch;
        logic     clear;
        logic     g_clr;
        logic     g_inc;
        logic     key_rd;
        logic     grp_new;
        logic     sum_rd;
        logic     ld_wr;
        logic     pa_wr;
        logic     i_clr;
        logic     i_inc;
        logic     val_rd;
        logic     mean_rd;
        logic     mul;
        logic     sq;
        logic     acc_wr;
        logic     set_computed;
        logic     slot_rd_q;
        logic     dev_rd_q;
        logic     div_start_mean;
        logic     div_start_q;
        logic     sqrt_start;
        logic     fin;
        t_status  fin_stat;
        t_res_sel fin_sel;
        logic     out_load;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_mode mode;
        logic  items_full;
        logic  groups_full;
        logic  g_end;
        logic  i_end;
        logic  idx_bad;
        logic  computed;
        logic  key_hit;
        logic  div_busy;
        logic  div_done;
        logic  sqrt_done;
        logic  op;
        logic  q_big;
        logic  out_free;
    } t_sts;

endpackage

[hdl/gvs_chan_if.sv]
// Interfaces: request and response channels of the grouped variance unit
`timescale 1ns / 1ps

interface gvs_req_if import gvs_pkg::*; ();
    logic                       valid;
    logic                       ready;
    t_mode                      mode;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [KEY_W-1:0]    group_id;
    logic [IDX_IN_W-1:0]        element_index;

    modport source (output valid, mode, sample, group_id, element_index, input ready);
    modport sink   (input valid, mode, sample, group_id, element_index, output ready);
endinterface

interface gvs_rsp_if import gvs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [RESULT_W-1:0] result;
    t_status             status;

    modport source (output valid, result, status, input ready);
    modport sink   (input valid, result, status, output ready);
endinterface

[hdl/gvs_div.sv]
// Iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module gvs_div import gvs_pkg::*; #(
    parameter int DEN_W = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DEV_W-1:0] i_dividend,
    input  logic [DEN_W-1:0] i_divisor,
    output logic             o_busy,
    output logic             o_done,
    output logic [DEV_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(DEV_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DEV_W-1:0]  r_quo;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;

    logic [DEN_W:0]    w_trial;
    logic [DEN_W:0]    w_diff;
    logic              w_ge;

    // One restoring step: bring down the next dividend bit
    always_comb begin
        w_trial = {r_rem, r_quo[DEV_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_ge    = (w_trial >= {1'b0, r_den});
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(DEV_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DEV_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

[hdl/gvs_sqrt.sv]
// Iterative integer square root, one root bit per cycle
`timescale 1ns / 1ps

module gvs_sqrt import gvs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DEV_W-1:0]  i_radicand,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    localparam int STEP_W = $clog2(ROOT_W + 1);
    localparam int REM_W  = ROOT_W + 2;
    localparam int TRY_W  = REM_W + 2;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DEV_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [TRY_W-1:0]  w_trial;
    logic [TRY_W-1:0]  w_sub;
    logic [TRY_W-1:0]  w_diff;
    logic              w_ge;

    // Bring down two radicand bits, try root*4+1
    always_comb begin
        w_trial = {r_rem, r_rad[DEV_W-1 -: 2]};
        w_sub   = {2'b00, r_root, 2'b01};
        w_diff  = w_trial - w_sub;
        w_ge    = (w_trial >= w_sub);
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(ROOT_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and root
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[DEV_W-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[REM_W-1:0] : w_trial[REM_W-1:0];
            r_root <= {r_root[ROOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

[hdl/gvs_ctrl.sv]
// Controller: state machine sequencing loads, second pass and queries
`timescale 1ns / 1ps
`include "grouped_variance_stddev_unit_assert.svh"

module gvs_ctrl import gvs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DECODE  = 5'd1;
    localparam logic [4:0] S_LD_SCAN = 5'd2;
    localparam logic [4:0] S_LD_CMP  = 5'd3;
    localparam logic [4:0] S_LD_RD   = 5'd4;
    localparam logic [4:0] S_LD_WR   = 5'd5;
    localparam logic [4:0] S_PA_RD   = 5'd6;
    localparam logic [4:0] S_PA_DIV  = 5'd7;
    localparam logic [4:0] S_PA_WAIT = 5'd8;
    localparam logic [4:0] S_PB_RD   = 5'd9;
    localparam logic [4:0] S_PB_MEAN = 5'd10;
    localparam logic [4:0] S_PB_MUL  = 5'd11;
    localparam logic [4:0] S_PB_SQ   = 5'd12;
    localparam logic [4:0] S_PB_ACC  = 5'd13;
    localparam logic [4:0] S_Q_SLOT  = 5'd14;
    localparam logic [4:0] S_Q_DEV   = 5'd15;
    localparam logic [4:0] S_Q_DIV   = 5'd16;
    localparam logic [4:0] S_Q_DWAIT = 5'd17;
    localparam logic [4:0] S_Q_SQ    = 5'd18;
    localparam logic [4:0] S_DONE    = 5'd19;

    logic [4:0] r_state;
    logic [4:0] n_state;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.mode)
                    MODE_LOAD: begin
                        if (i_sts.items_full) begin
                            o_cmd.fin      = 1'b1;
                            o_cmd.fin_stat = ST_STORE_FULL;
                            n_state        = S_DONE;
                        end else begin
                            o_cmd.g_clr = 1'b1;
                            n_state     = S_LD_SCAN;
                        end
                    end
                    MODE_QUERY: begin
                        if (i_sts.idx_bad) begin
                            o_cmd.fin      = 1'b1;
                            o_cmd.fin_stat = ST_BAD_INDEX;
                            n_state        = S_DONE;
                        end else if (i_sts.computed) begin
                            n_state = S_Q_SLOT;
                        end else begin
                            o_cmd.g_clr = 1'b1;
                            n_state     = S_PA_RD;
                        end
                    end
                    MODE_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        o_cmd.fin   = 1'b1;
                        n_state     = S_DONE;
                    end
                    MODE_NONE: begin
                        o_cmd.fin = 1'b1;
                        n_state   = S_DONE;
                    end
                endcase
            end
            // Group lookup, one registered key read and compare per table entry
            S_LD_SCAN: begin
                if (i_sts.g_end) begin
                    if (i_sts.groups_full) begin
                        o_cmd.fin      = 1'b1;
                        o_cmd.fin_stat = ST_GROUP_FULL;
                        n_state        = S_DONE;
                    end else begin
                        o_cmd.grp_new = 1'b1;
                        n_state       = S_LD_WR;
                    end
                end else begin
                    o_cmd.key_rd = 1'b1;
                    n_state      = S_LD_CMP;
                end
            end
            S_LD_CMP: begin
                if (i_sts.key_hit) begin
                    n_state = S_LD_RD;
                end else begin
                    o_cmd.g_inc = 1'b1;
                    n_state     = S_LD_SCAN;
                end
            end
            S_LD_RD: begin
                o_cmd.sum_rd = 1'b1;
                n_state      = S_LD_WR;
            end
            S_LD_WR: begin
                o_cmd.ld_wr = 1'b1;
                o_cmd.fin   = 1'b1;
                n_state     = S_DONE;
            end
            // Second pass, part one: group means
            S_PA_RD: begin
                if (i_sts.g_end) begin
                    o_cmd.i_clr = 1'b1;
                    n_state     = S_PB_RD;
                end else begin
                    o_cmd.sum_rd = 1'b1;
                    n_state      = S_PA_DIV;
                end
            end
            S_PA_DIV: begin
                o_cmd.div_start_mean = 1'b1;
                n_state              = S_PA_WAIT;
            end
            S_PA_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.pa_wr = 1'b1;
                    o_cmd.g_inc = 1'b1;
                    n_state     = S_PA_RD;
                end
            end
            // Second pass, part two: squared deviations per element
            S_PB_RD: begin
                if (i_sts.i_end) begin
                    o_cmd.set_computed = 1'b1;
                    n_state            = S_Q_SLOT;
                end else begin
                    o_cmd.val_rd = 1'b1;
                    n_state      = S_PB_MEAN;
                end
            end
            S_PB_MEAN: begin
                o_cmd.mean_rd = 1'b1;
                n_state       = S_PB_MUL;
            end
            S_PB_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_PB_SQ;
            end
            S_PB_SQ: begin
                o_cmd.sq = 1'b1;
                n_state  = S_PB_ACC;
            end
            S_PB_ACC: begin
                o_cmd.acc_wr = 1'b1;
                o_cmd.i_inc  = 1'b1;
                n_state      = S_PB_RD;
            end
            // Query answer
            S_Q_SLOT: begin
                o_cmd.slot_rd_q = 1'b1;
                n_state         = S_Q_DEV;
            end
            S_Q_DEV: begin
                o_cmd.dev_rd_q = 1'b1;
                n_state        = S_Q_DIV;
            end
            S_Q_DIV: begin
                o_cmd.div_start_q = 1'b1;
                n_state           = S_Q_DWAIT;
            end
            S_Q_DWAIT: begin
                if (i_sts.div_done) begin
                    if (i_sts.op == OP_VARIANCE || i_sts.q_big) begin
                        o_cmd.fin     = 1'b1;
                        o_cmd.fin_sel = SEL_QUO;
                        n_state       = S_DONE;
                    end else begin
                        o_cmd.sqrt_start = 1'b1;
                        n_state          = S_Q_SQ;
                    end
                end
            end
            S_Q_SQ: begin
                if (i_sts.sqrt_done) begin
                    o_cmd.fin     = 1'b1;
                    o_cmd.fin_sel = SEL_ROOT;
                    n_state       = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Checks
    `GVS_ASSERT_NEXT(a_accept_decode, i_clk, i_rst_n, o_req_ready && i_req_valid, r_state == S_DECODE, "accepted request not decoded")
    `GVS_ASSERT_NEXT(a_fin_done, i_clk, i_rst_n, o_cmd.fin, r_state == S_DONE, "finished request not delivered")
    `GVS_ASSERT_NOW(a_div_free, i_clk, i_rst_n, o_cmd.div_start_mean || o_cmd.div_start_q, !i_sts.div_busy, "divider started while busy")

endmodule

[hdl/gvs_dp.sv]
// Datapath: stores, group tables, arithmetic and response register
`timescale 1ns / 1ps
`include "grouped_variance_stddev_unit_assert.svh"

module gvs_dp import gvs_pkg::*; #(
    parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
    parameter int MAX_GROUPS = DEF_MAX_GROUPS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [0:0]          i_cfg_wr_data,
    input  t_mode               i_mode,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [KEY_W-1:0]    i_group_id,
    input  logic [IDX_IN_W-1:0] i_element_index,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    gvs_rsp_if.source           o_rsp
);

    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W  = $clog2(MAX_ITEMS);
    localparam int GCNT_W = $clog2(MAX_GROUPS + 1);
    localparam int GIDX_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int SUM_W  = SAMPLE_W + IDX_W;
    localparam int CMP_W  = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;

    // Stores
    logic [SAMPLE_W-1:0] value_mem [MAX_ITEMS];
    logic [GIDX_W-1:0]   slot_mem  [MAX_ITEMS];
    logic [KEY_W-1:0]    key_mem   [MAX_GROUPS];
    logic [SUM_W-1:0]    sum_mem   [MAX_GROUPS];
    logic [CNT_W-1:0]    cnt_mem   [MAX_GROUPS];
    logic [SAMPLE_W-1:0] mean_mem  [MAX_GROUPS];
    logic [DEV_W-1:0]    dev_mem   [MAX_GROUPS];

    // Control state
    logic              r_op;
    logic [GCNT_W-1:0] r_groups;
    logic [CNT_W-1:0]  r_items;
    logic              r_computed;
    logic [GCNT_W-1:0] r_g;
    logic [CNT_W-1:0]  r_i;
    logic              r_out_valid;

    // Request and working registers
    t_mode               r_mode;
    logic [SAMPLE_W-1:0] r_sample;
    logic [KEY_W-1:0]    r_gkey;
    logic [IDX_IN_W-1:0] r_idx;
    logic                r_new;
    logic [KEY_W-1:0]    r_key_q;
    logic [SUM_W-1:0]    r_sum_q;
    logic [CNT_W-1:0]    r_cnt_q;
    logic [SAMPLE_W-1:0] r_val_q;
    logic [GIDX_W-1:0]   r_slot_q;
    logic [SAMPLE_W-1:0] r_mean_q;
    logic [DEV_W-1:0]    r_dev_q;
    logic [31:0]         r_mag;
    logic [DEV_W-1:0]    r_prod;
    logic [RESULT_W-1:0] r_res;
    t_status             r_res_stat;
    logic [RESULT_W-1:0] r_out_res;
    t_status             r_out_stat;

    logic [CMP_W-1:0]    w_idx_ext;
    logic [CMP_W-1:0]    w_items_ext;
    logic [GIDX_W-1:0]   w_gaddr;
    logic [IDX_W-1:0]    w_iaddr;
    logic [IDX_W-1:0]    w_ld_addr;
    logic [GIDX_W-1:0]   w_grd_addr;
    logic [GIDX_W-1:0]   w_dev_waddr;
    logic [DEV_W-1:0]    w_dev_wdata;
    logic [SUM_W-1:0]    w_sum_new;
    logic [CNT_W-1:0]    w_cnt_new;
    logic [SUM_W-1:0]    w_sum_abs;
    logic [SAMPLE_W:0]   w_d;
    logic [SAMPLE_W:0]   w_dneg;
    logic [31:0]         w_mag;
    logic [DEV_W-1:0]    w_sq;
    logic [DEV_W:0]      w_acc;
    logic [DEV_W-1:0]    w_acc_sat;
    logic [SAMPLE_W-1:0] w_mean;
    logic [DEV_W-1:0]    w_quo_neg;
    logic [RESULT_W-1:0] w_var;
    logic [RESULT_W-1:0] w_fin_val;

    logic                w_div_start;
    logic [DEV_W-1:0]    w_div_dividend;
    logic                w_div_busy;
    logic                w_div_done;
    logic [DEV_W-1:0]    w_quo;
    logic                w_sqrt_done;
    logic [ROOT_W-1:0]   w_root;
    logic                w_out_take;

    // Addresses
    always_comb begin
        w_idx_ext   = CMP_W'(r_idx);
        w_items_ext = CMP_W'(r_items);
        w_gaddr     = r_g[GIDX_W-1:0];
        w_iaddr     = i_cmd.slot_rd_q ? w_idx_ext[IDX_W-1:0] : r_i[IDX_W-1:0];
        w_ld_addr   = r_items[IDX_W-1:0];
        w_grd_addr  = i_cmd.sum_rd ? w_gaddr : r_slot_q;
        w_dev_waddr = i_cmd.pa_wr ? w_gaddr : r_slot_q;
        w_dev_wdata = i_cmd.pa_wr ? '0 : w_acc_sat;
    end

    // Load update of the group running sum and count
    always_comb begin
        w_sum_new = (r_new ? '0 : r_sum_q)
                  + {{(SUM_W - SAMPLE_W){r_sample[SAMPLE_W-1]}}, r_sample};
        w_cnt_new = (r_new ? '0 : r_cnt_q) + 1'b1;
    end

    // Mean: magnitude division, sign restored after
    always_comb begin
        w_sum_abs = r_sum_q[SUM_W-1] ? (~r_sum_q + 1'b1) : r_sum_q;
        w_quo_neg = ~w_quo + 1'b1;
        w_mean    = r_sum_q[SUM_W-1] ? w_quo_neg[SAMPLE_W-1:0] : w_quo[SAMPLE_W-1:0];
    end

    // Deviation magnitude and saturating accumulate
    always_comb begin
        w_d       = {r_mean_q[SAMPLE_W-1], r_mean_q} - {r_val_q[SAMPLE_W-1], r_val_q};
        w_dneg    = ~w_d + 1'b1;
        w_mag     = w_d[SAMPLE_W] ? w_dneg[31:0] : w_d[31:0];
        w_sq      = r_prod >> FRAC_BITS;
        w_acc     = {1'b0, r_dev_q} + {1'b0, w_sq};
        w_acc_sat = w_acc[DEV_W] ? '1 : w_acc[DEV_W-1:0];
    end

    // Result selection
    always_comb begin
        w_var = (w_quo[DEV_W-1:RESULT_W] != '0) ? '1 : w_quo[RESULT_W-1:0];
        unique case (i_cmd.fin_sel)
            SEL_QUO:  w_fin_val = w_var;
            SEL_ROOT: w_fin_val = w_root;
            default:  w_fin_val = '0;
        endcase
    end

    // Divider operands
    always_comb begin
        w_div_start    = i_cmd.div_start_mean || i_cmd.div_start_q;
        w_div_dividend = i_cmd.div_start_mean ? {{(DEV_W - SUM_W){1'b0}}, w_sum_abs}
                                              : r_dev_q;
    end

    gvs_div #(
        .DEN_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (r_cnt_q),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_quo)
    );

    gvs_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sqrt_start),
        .i_radicand (w_quo << FRAC_BITS),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    // Element stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_wr) begin
            value_mem[w_ld_addr] <= r_sample;
            slot_mem[w_ld_addr]  <= w_gaddr;
        end
        if (i_cmd.val_rd) begin
            r_val_q <= value_mem[w_iaddr];
        end
        if (i_cmd.val_rd || i_cmd.slot_rd_q) begin
            r_slot_q <= slot_mem[w_iaddr];
        end
    end

    // Group key table
    always_ff @(posedge i_clk) begin
        if (i_cmd.grp_new) begin
            key_mem[w_gaddr] <= r_gkey;
        end
        if (i_cmd.key_rd) begin
            r_key_q <= key_mem[w_gaddr];
        end
    end

    // Group sums and counts
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_wr) begin
            sum_mem[w_gaddr] <= w_sum_new;
            cnt_mem[w_gaddr] <= w_cnt_new;
        end
        if (i_cmd.sum_rd) begin
            r_sum_q <= sum_mem[w_grd_addr];
        end
        if (i_cmd.sum_rd || i_cmd.dev_rd_q) begin
            r_cnt_q <= cnt_mem[w_grd_addr];
        end
    end

    // Group means
    always_ff @(posedge i_clk) begin
        if (i_cmd.pa_wr) begin
            mean_mem[w_gaddr] <= w_mean;
        end
        if (i_cmd.mean_rd) begin
            r_mean_q <= mean_mem[r_slot_q];
        end
    end

    // Deviation sums
    always_ff @(posedge i_clk) begin
        if (i_cmd.pa_wr || i_cmd.acc_wr) begin
            dev_mem[w_dev_waddr] <= w_dev_wdata;
        end
        if (i_cmd.mean_rd || i_cmd.dev_rd_q) begin
            r_dev_q <= dev_mem[r_slot_q];
        end
    end

    // Request capture and arithmetic stages
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode   <= i_mode;
            r_sample <= i_sample;
            r_gkey   <= i_group_id;
            r_idx    <= i_element_index;
        end
        if (i_cmd.latch) begin
            r_new <= 1'b0;
        end else if (i_cmd.grp_new) begin
            r_new <= 1'b1;
        end
        if (i_cmd.mul) begin
            r_mag <= w_mag;
        end
        if (i_cmd.sq) begin
            r_prod <= DEV_W'(r_mag) * DEV_W'(r_mag);
        end
        if (i_cmd.fin) begin
            r_res      <= w_fin_val;
            r_res_stat <= i_cmd.fin_stat;
        end
        if (i_cmd.out_load) begin
            r_out_res  <= r_res;
            r_out_stat <= r_res_stat;
        end
    end

    assign w_out_take = r_out_valid && o_rsp.ready;

    // Counters, flags and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op        <= OP_STDDEV;
            r_groups    <= '0;
            r_items     <= '0;
            r_computed  <= 1'b0;
            r_g         <= '0;
            r_i         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_op <= i_cfg_wr_data[0];
            end
            if (i_cmd.clear) begin
                r_groups   <= '0;
                r_items    <= '0;
                r_computed <= 1'b0;
            end else if (i_cmd.ld_wr) begin
                // a new group is counted together with its first element
                if (r_new) begin
                    r_groups <= r_groups + 1'b1;
                end
                r_items    <= r_items + 1'b1;
                r_computed <= 1'b0;
            end else if (i_cmd.set_computed) begin
                r_computed <= 1'b1;
            end
            if (i_cmd.g_clr) begin
                r_g <= '0;
            end else if (i_cmd.g_inc) begin
                r_g <= r_g + 1'b1;
            end
            if (i_cmd.i_clr) begin
                r_i <= '0;
            end else if (i_cmd.i_inc) begin
                r_i <= r_i + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Status to the controller
    always_comb begin
        o_sts.mode        = r_mode;
        o_sts.items_full  = (r_items == CNT_W'(MAX_ITEMS));
        o_sts.groups_full = (r_groups == GCNT_W'(MAX_GROUPS));
        o_sts.g_end       = (r_g == r_groups);
        o_sts.i_end       = (r_i == r_items);
        o_sts.idx_bad     = (w_idx_ext >= w_items_ext);
        o_sts.computed    = r_computed;
        o_sts.key_hit     = (r_key_q == r_gkey);
        o_sts.div_busy    = w_div_busy;
        o_sts.div_done    = w_div_done;
        o_sts.sqrt_done   = w_sqrt_done;
        o_sts.op          = r_op;
        o_sts.q_big       = ((w_quo >> (DEV_W - FRAC_BITS)) != '0);
        o_sts.out_free    = !r_out_valid || o_rsp.ready;
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.result = r_out_res;
    assign o_rsp.status = r_out_stat;

    // Checks
    `GVS_ASSERT_NOW(a_groups_bound, i_clk, i_rst_n, 1'b1, r_groups <= GCNT_W'(MAX_GROUPS), "group count beyond table size")
    `GVS_ASSERT_NOW(a_items_bound, i_clk, i_rst_n, 1'b1, r_items <= CNT_W'(MAX_ITEMS), "item count beyond store size")
    `GVS_ASSERT_NOW(a_groups_items, i_clk, i_rst_n, 1'b1, CNT_W'(r_groups) <= r_items, "group without an element")

endmodule

[hdl/grouped_variance_stddev_unit.sv]
// Grouped variance / standard deviation unit (top level)
// Use: requests arrive on i_req (valid/ready); each request gives exactly one
// response on o_rsp (result, status). Mode load stores a signed Q16.16 sample
// under a group key, query returns the variance or standard deviation of the
// queried element's group, clear empties the data set. The operation
// register (i_cfg_wr_en / i_cfg_wr_data) picks standard deviation (0) or
// variance (1), to be written only while the unit is idle (not enforced).
// A clear or an unused mode goes from decode straight to the response
// register. A load scans the group table (one registered read and compare
// per entry), then writes the sample and the group's new sum and count. A
// query on computed data runs the bit-serial divider (64 steps) and, for
// standard deviation, the square root (32 steps) after it. The first query
// after a load or clear adds a second pass: one mean division per group,
// then one deviation update per element.
// One request is worked on at a time; a new one is taken while the previous
// response still waits in the output register.
// Reset (synchronous, active low) empties the data set and selects standard
// deviation. When the receiver stalls, the finished response is held and the
// unit waits before delivering the next one.
`timescale 1ns / 1ps

module grouped_variance_stddev_unit import gvs_pkg::*; #(
    parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
    parameter int MAX_GROUPS = DEF_MAX_GROUPS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [0:0] i_cfg_wr_data,
    gvs_req_if.sink    i_req,
    gvs_rsp_if.source  o_rsp
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_req_ready;

    assign i_req.ready = w_req_ready;

    gvs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    gvs_dp #(
        .MAX_ITEMS  (MAX_ITEMS),
        .MAX_GROUPS (MAX_GROUPS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_mode          (i_req.mode),
        .i_sample        (i_req.sample),
        .i_group_id      (i_req.group_id),
        .i_element_index (i_req.element_index),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_rsp           (o_rsp)
    );

endmodule

[dv/tb_grouped_variance_stddev_unit.sv]
// Testbench for the grouped variance / standard deviation unit, self-checking
`timescale 1ns / 1ps

module tb_grouped_variance_stddev_unit import gvs_pkg::*; ();

    localparam int CLK_HALF   = 6;
    localparam int STORE_SIZE = DEF_MAX_ITEMS;
    localparam int GROUP_SIZE = DEF_MAX_GROUPS;
    localparam int FRAC       = DEF_FRAC_BITS;

    typedef struct packed {
        logic [RESULT_W-1:0] result;
        t_status             status;
    } t_response;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [0:0] i_cfg_wr_data;

    gvs_req_if req_if ();
    gvs_rsp_if rsp_if ();

    grouped_variance_stddev_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (req_if),
        .o_rsp         (rsp_if)
    );

    // Shadow copy of the unit's data set
    logic signed [SAMPLE_W-1:0] shadow_values [STORE_SIZE];
    int unsigned                shadow_slots  [STORE_SIZE];
    logic [KEY_W-1:0]           shadow_keys   [GROUP_SIZE];
    longint                     shadow_sums   [GROUP_SIZE];
    int unsigned                shadow_counts [GROUP_SIZE];
    logic [DEV_W-1:0]           shadow_devs   [GROUP_SIZE];
    int unsigned                shadow_groups;
    int unsigned                shadow_items;
    bit                         shadow_computed;
    logic                       shadow_op;

    t_response pending_rsp [$];
    int        error_count;
    bit        no_idle;
    int        hold_len;
    int        hold_stamp;

    // Clock
    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // Run limit
    initial begin
        #30ms;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report(input string what);
        error_count++;
        if (error_count <= 40) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Integer square root, floor
    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] bitv;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x    = x - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Means, then summed squared deviations per group
    function automatic void deviation_pass();
        longint       mean;
        longint       dev;
        logic [63:0]  mag;
        logic [127:0] sq;
        int unsigned  s;
        for (int g = 0; g < shadow_groups; g++) shadow_devs[g] = '0;
        for (int i = 0; i < shadow_items; i++) begin
            s = shadow_slots[i];
            if (shadow_counts[s] == 0) continue;
            mean = shadow_sums[s] / longint'(shadow_counts[s]);
            dev  = mean - longint'(shadow_values[i]);
            mag  = (dev < 0) ? 64'(-dev) : 64'(dev);
            sq   = ({64'd0, mag} * {64'd0, mag}) >> FRAC;
            if ({64'd0, shadow_devs[s]} + sq > 128'hFFFF_FFFF_FFFF_FFFF)
                shadow_devs[s] = '1;
            else
                shadow_devs[s] = shadow_devs[s] + sq[63:0];
        end
        shadow_computed = 1'b1;
    endfunction

    // Expected response of one accepted request, updating the shadow state
    function automatic t_response predict_response(input t_mode mode,
            input logic signed [31:0] sample, input logic [31:0] key,
            input logic [9:0] idx);
        t_response   rsp;
        int unsigned g;
        int unsigned s;
        logic [63:0] q;
        rsp = '{result: '0, status: ST_OK};
        case (mode)
            MODE_LOAD: begin
                if (shadow_items >= STORE_SIZE) begin
                    rsp.status = ST_STORE_FULL;
                end else begin
                    for (g = 0; g < shadow_groups; g++)
                        if (shadow_keys[g] == key) break;
                    if (g == shadow_groups && shadow_groups >= GROUP_SIZE) begin
                        rsp.status = ST_GROUP_FULL;
                    end else begin
                        if (g == shadow_groups) begin
                            shadow_keys[g]   = key;
                            shadow_sums[g]   = 0;
                            shadow_counts[g] = 0;
                            shadow_groups++;
                        end
                        shadow_values[shadow_items] = sample;
                        shadow_slots[shadow_items]  = g;
                        shadow_sums[g] += longint'(sample);
                        shadow_counts[g]++;
                        shadow_items++;
                        shadow_computed = 1'b0;
                    end
                end
            end
            MODE_QUERY: begin
                if (idx >= shadow_items) begin
                    rsp.status = ST_BAD_INDEX;
                end else begin
                    if (!shadow_computed) deviation_pass();
                    s = shadow_slots[idx];
                    q = (shadow_counts[s] != 0) ? shadow_devs[s] / shadow_counts[s] : '0;
                    if (shadow_op == OP_VARIANCE)
                        rsp.result = (q[63:32] != 0) ? '1 : q[31:0];
                    else if (q[63:48] != 0)
                        rsp.result = '1;
                    else begin
                        q = int_sqrt(q << FRAC);
                        rsp.result = (q[63:32] != 0) ? '1 : q[31:0];
                    end
                end
            end
            MODE_CLEAR: begin
                shadow_groups   = 0;
                shadow_items    = 0;
                shadow_computed = 1'b0;
            end
            default: ;
        endcase
        return rsp;
    endfunction

    // Offer one request, wait for its acceptance, queue its expected response
    task automatic send_request(input t_mode mode, input logic [31:0] sample,
            input logic [31:0] key, input logic [9:0] idx);
        int gap;
        int r;
        r   = $urandom_range(0, 99);
        gap = (no_idle || r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3)
                                                 : $urandom_range(10, 40);
        if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid         = 1'b1;
        req_if.mode          = mode;
        req_if.sample        = sample;
        req_if.group_id      = key;
        req_if.element_index = idx;
        @(posedge i_clk);
        while (!(req_if.valid && req_if.ready)) @(posedge i_clk);
        pending_rsp.push_back(predict_response(mode, sample, key, idx));
        @(negedge i_clk);
    endtask

    task automatic send_load(input logic [31:0] sample, input logic [31:0] key);
        send_request(MODE_LOAD, sample, key, 10'($urandom));
    endtask

    task automatic send_query(input logic [9:0] idx);
        send_request(MODE_QUERY, $urandom, $urandom, idx);
    endtask

    // Pause the sender until every response has come in
    task automatic wait_drained();
        req_if.valid = 1'b0;
        while (pending_rsp.size() != 0) @(negedge i_clk);
    endtask

    // Operation register write, only with the unit idle
    task automatic set_operation(input logic op);
        wait_drained();
        repeat (8) @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = op;
        shadow_op     = op;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
    endtask

    // Response checker
    always @(posedge i_clk) begin
        t_response exp_rsp;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_rsp.size() == 0) begin
                report($sformatf("response with none pending: result %h status %0d",
                                 rsp_if.result, rsp_if.status));
            end else begin
                exp_rsp = pending_rsp.pop_front();
                if (rsp_if.result !== exp_rsp.result)
                    report($sformatf("result %h, expected %h",
                                     rsp_if.result, exp_rsp.result));
                if (rsp_if.status !== exp_rsp.status)
                    report($sformatf("status %0d, expected %0d",
                                     rsp_if.status, exp_rsp.status));
            end
        end
    end

    // Receiver: random stalls, plus long hold-offs on demand
    initial begin
        int stall_left;
        int seen_stamp;
        int r;
        stall_left   = 0;
        seen_stamp   = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_stamp != seen_stamp) begin
                seen_stamp = hold_stamp;
                stall_left = hold_len;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready = 1'b0;
            end else if (no_idle) begin
                rsp_if.ready = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) rsp_if.ready = 1'b1;
                else begin
                    rsp_if.ready = 1'b0;
                    stall_left   = (r < 96) ? $urandom_range(0, 2) : $urandom_range(15, 60);
                end
            end
        end
    end

    // Empty unit: bad indices, unused mode, clear
    task automatic test_empty_requests();
        send_query(10'd0);
        send_query(10'd1023);
        send_request(MODE_NONE, '1, '1, '1);
        send_request(MODE_CLEAR, '0, '0, '0);
        send_query(10'd0);
    endtask

    // Extreme samples and keys, both operations, load after query
    task automatic test_directed_groups();
        send_load(32'h7FFF_FFFF, 32'h8000_0000);
        send_load(32'h8000_0000, 32'h8000_0000);
        send_load(32'h0000_0000, 32'h7FFF_FFFF);
        send_load(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_load(32'h0001_0000, 32'hFFFF_FFFF);
        send_query(10'd0);
        send_query(10'd2);
        send_query(10'd4);
        send_query(10'd5);
        send_load(32'h0003_8000, 32'h7FFF_FFFF);
        send_query(10'd2);
        send_request(MODE_NONE, '0, '0, '0);
        set_operation(OP_VARIANCE);
        send_query(10'd0);
        send_query(10'd3);
        send_query(10'd5);
        set_operation(OP_STDDEV);
        send_query(10'd1);
    endtask

    // Group table fills, further new keys are refused
    task automatic test_group_table_full();
        send_request(MODE_CLEAR, $urandom, $urandom, 10'($urandom));
        for (int g = 0; g < GROUP_SIZE; g++)
            send_load($urandom, 32'h1000_0000 + g * 32'h0101);
        send_load($urandom, 32'hDEAD_0001);
        send_load($urandom, 32'h1000_0000);
        send_query(10'd0);
        send_query(10'd64);
        send_query(10'd65);
    endtask

    // Store fills, the next load is refused
    task automatic test_store_full();
        no_idle = 1'b1;
        send_request(MODE_CLEAR, $urandom, $urandom, 10'($urandom));
        for (int i = 0; i < STORE_SIZE; i++)
            send_load($urandom_range(0, 32'h00FF_FFFF), 32'($urandom_range(0, 2)));
        send_load($urandom, 32'd0);
        no_idle = 1'b0;
        send_query(10'd0);
        send_query(10'd1023);
    endtask

    // Receiver holds off long while requests keep coming
    task automatic test_backpressure();
        set_operation(OP_VARIANCE);
        send_request(MODE_CLEAR, $urandom, $urandom, 10'($urandom));
        hold_len = 400;
        hold_stamp++;
        for (int i = 0; i < 8; i++) send_load($urandom, 32'($urandom_range(0, 1)));
        send_query(10'd3);
        send_query(10'd6);
        wait_drained();
    endtask

    // Random data sets: loads, queries, a little noise, then clear
    task automatic test_random_sets();
        int sent;
        int set_size;
        int pool;
        logic [31:0] keys [8];
        logic [31:0] base;
        int r;
        sent = 0;
        while (sent < 450) begin
            set_operation(logic'($urandom_range(0, 1)));
            no_idle  = ($urandom_range(0, 4) == 0);
            pool     = $urandom_range(1, 8);
            set_size = $urandom_range(2, 24);
            base     = $urandom;
            foreach (keys[k]) keys[k] = $urandom;
            for (int i = 0; i < set_size + 12; i++) begin
                r = $urandom_range(0, 99);
                if (i < set_size || r < 20) begin
                    r = $urandom_range(0, 9);
                    send_load((r == 0) ? 32'h8000_0000 : (r == 1) ? 32'h7FFF_FFFF :
                              (r < 5) ? $urandom :
                              base + $urandom_range(0, 32'h0004_0000),
                              keys[$urandom_range(0, pool - 1)]);
                end else if (r < 88) begin
                    send_query(10'($urandom_range(0, shadow_items - 1)));
                end else if (r < 95) begin
                    send_query(10'($urandom));
                end else begin
                    send_request(MODE_NONE, $urandom, $urandom, 10'($urandom));
                end
                sent++;
            end
            send_request(MODE_CLEAR, $urandom, $urandom, 10'($urandom));
            sent++;
        end
        no_idle = 1'b0;
    endtask

    // Sequence of tests
    initial begin
        error_count          = 0;
        no_idle              = 1'b0;
        hold_len             = 0;
        hold_stamp           = 0;
        shadow_groups        = 0;
        shadow_items         = 0;
        shadow_computed      = 1'b0;
        shadow_op            = OP_STDDEV;
        i_rst_n              = 1'b0;
        i_cfg_wr_en          = 1'b0;
        i_cfg_wr_data        = '0;
        req_if.valid         = 1'b0;
        req_if.mode          = MODE_NONE;
        req_if.sample        = '0;
        req_if.group_id      = '0;
        req_if.element_index = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_empty_requests();
        test_directed_groups();
        test_group_table_full();
        test_store_full();
        test_backpressure();
        test_random_sets();

        wait_drained();
        repeat (200) @(negedge i_clk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
